// File: design/fcba_pkg.sv
package fcba_pkg;

    localparam int MAX_BLOCKS_DEF  = 4096;
    localparam int BLOCK_BYTES_DEF = 512;
    localparam int MIN_BLOCKS      = 4;
    localparam int ENTRY_BYTES     = 4;
    localparam int META_BYTES      = 8;
    localparam int SIZE_WORD_OFF   = 4;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

    // input opcodes
    localparam logic [1:0] OP_FORMAT = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // result kinds
    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_META  = 3'd1;
    localparam logic [2:0] K_START = 3'd2;
    localparam logic [2:0] K_ROOT  = 3'd3;
    localparam logic [2:0] K_READ  = 3'd4;
    localparam logic [2:0] K_FULL  = 3'd5;

    // result select from the controller
    localparam logic [2:0] RES_DATA  = 3'd0;
    localparam logic [2:0] RES_META  = 3'd1;
    localparam logic [2:0] RES_SIZE  = 3'd2;
    localparam logic [2:0] RES_START = 3'd3;
    localparam logic [2:0] RES_ROOT  = 3'd4;
    localparam logic [2:0] RES_READ  = 3'd5;
    localparam logic [2:0] RES_FULL  = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [11:0] entry_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] block_number;
        logic [8:0]  byte_offset;
        logic [20:0] value;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic       accept;
        logic       direct;
        logic       fmt_latch;
        logic       sweep;
        logic       sweep_fmt;
        logic       fmt_finish;
        logic       rd_en;
        logic       rd_pop;
        logic       pop_commit;
        logic       link;
        logic       emit;
        logic [2:0] res_sel;
        logic       step_byte;
        logic       close_file;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       need_pop;
        logic       list_empty;
        logic       file_open;
        logic       out_free;
        logic       sweep_last;
    } dp_sts_t;

endpackage

// File: design/fcba_dp.sv
module fcba_dp #(
    parameter int MAX_BLOCKS  = fcba_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = fcba_pkg::BLOCK_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [fcba_pkg::CFG_W-1:0]   cfg_wr_data,
    input  fcba_pkg::in_item_t           s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fcba_pkg::out_item_t          m_item,
    input  fcba_pkg::dp_cmd_t            cmd,
    output fcba_pkg::dp_sts_t            sts
);
    import fcba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int FD_W  = IDX_W + 1;
    localparam int FO_W  = $clog2(BLOCK_BYTES) + 1;
    localparam int BB_SH = $clog2(BLOCK_BYTES);

    logic [CFG_W-1:0] total_blocks_reg;
    in_item_t         item_reg;

    logic [IDX_W-1:0] alloc_mem [MAX_BLOCKS];
    logic [IDX_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic [IDX_W-1:0] n_m1_reg;
    logic [FD_W-1:0]  first_reg;

    logic [IDX_W-1:0] free_head_reg;
    logic             file_open_reg;
    logic [IDX_W-1:0] start_reg;
    logic [IDX_W-1:0] current_reg;
    logic [IDX_W-1:0] prev_reg;
    logic [FO_W-1:0]  fill_reg;
    logic [20:0]      size_reg;

    logic             m_valid_reg;
    out_item_t        m_item_reg, res;

    logic [31:0]      n_val, fmt_sum, first_val;
    logic [IDX_W-1:0] fmt_entry;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa, mem_wd, mem_ra;
    logic             out_free, sweep_last, idx_ok, need_pop;
    logic [7:0]       byte_sel;

    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_last = (sweep_reg == IDX_W'(MAX_BLOCKS - 1));
    assign sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
    assign idx_ok     = (32'(item_reg.entry_index) < 32'(MAX_BLOCKS));
    assign need_pop   = !file_open_reg || (fill_reg >= FO_W'(BLOCK_BYTES));
    assign byte_sel   = cmd.direct ? s_item.data_byte : item_reg.data_byte;

    // clamp block count and find the first data block after the table blocks
    always_comb begin
        if (32'(total_blocks_reg) < 32'(MIN_BLOCKS)) begin
            n_val = 32'(MIN_BLOCKS);
        end else if (32'(total_blocks_reg) > 32'(MAX_BLOCKS)) begin
            n_val = 32'(MAX_BLOCKS);
        end else begin
            n_val = 32'(total_blocks_reg);
        end
        fmt_sum   = (n_val << 2) + 32'(BLOCK_BYTES - 1);
        first_val = (fmt_sum >> BB_SH) + 32'd1;
    end

    // free chain runs from n-2 down to the first data block; root n-1 is left out
    assign fmt_entry = ({1'b0, sweep_reg} > first_reg && sweep_reg < n_m1_reg)
                       ? sweep_reg - 1'b1 : '0;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = '0;
        if (cmd.sweep) begin
            mem_we = 1'b1;
            mem_wd = cmd.sweep_fmt ? fmt_entry : '0;
        end else if (cmd.pop_commit) begin
            mem_we = 1'b1;
            mem_wa = free_head_reg;
        end else if (cmd.link) begin
            mem_we = 1'b1;
            mem_wa = prev_reg;
            mem_wd = current_reg;
        end
    end

    assign mem_ra = cmd.rd_pop ? free_head_reg : IDX_W'(item_reg.entry_index);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            alloc_mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= alloc_mem[mem_ra];
        end
        if (cmd.accept) begin
            item_reg <= s_item;
        end
        if (cmd.fmt_latch) begin
            n_m1_reg  <= IDX_W'(n_val - 32'd1);
            first_reg <= FD_W'(first_val);
        end
    end

    always_comb begin
        res = '0;
        res.last = 1'b1;
        case (cmd.res_sel)
            RES_DATA: begin
                res.kind         = K_DATA;
                res.block_number = 12'(current_reg);
                res.byte_offset  = 9'(fill_reg);
                res.value        = 21'(byte_sel);
            end
            RES_META: begin
                res.kind         = K_META;
                res.block_number = 12'(start_reg);
                res.value        = 21'd1;
                res.last         = 1'b0;
            end
            RES_SIZE: begin
                res.kind         = K_META;
                res.block_number = 12'(start_reg);
                res.byte_offset  = 9'(SIZE_WORD_OFF);
                res.value        = size_reg;
                res.last         = 1'b0;
            end
            RES_START: begin
                res.kind         = K_START;
                res.block_number = 12'(start_reg);
            end
            RES_ROOT: begin
                res.kind         = K_ROOT;
                res.block_number = 12'(n_m1_reg);
            end
            RES_READ: begin
                res.kind         = K_READ;
                res.block_number = item_reg.entry_index;
                res.value        = idx_ok ? 21'(rd_data_reg) : '0;
            end
            default: begin
                res.kind = K_FULL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_blocks_reg <= TOTAL_BLOCKS_RST;
            sweep_reg        <= '0;
            free_head_reg    <= '0;
            file_open_reg    <= 1'b0;
            start_reg        <= '0;
            current_reg      <= '0;
            prev_reg         <= '0;
            fill_reg         <= '0;
            size_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                total_blocks_reg <= cfg_wr_data;
            end
            if (cmd.sweep) begin
                sweep_reg <= sweep_next;
            end
            if (cmd.fmt_finish) begin
                // root block n-1 is popped right away
                free_head_reg <= ({1'b0, n_m1_reg} > first_reg) ? n_m1_reg - 1'b1 : '0;
                file_open_reg <= 1'b0;
                start_reg     <= '0;
                current_reg   <= '0;
                fill_reg      <= '0;
                size_reg      <= '0;
            end
            if (cmd.pop_commit) begin
                free_head_reg <= rd_data_reg;
                current_reg   <= free_head_reg;
                if (!file_open_reg) begin
                    start_reg     <= free_head_reg;
                    fill_reg      <= FO_W'(META_BYTES);
                    size_reg      <= '0;
                    file_open_reg <= 1'b1;
                end else begin
                    prev_reg <= current_reg;
                    fill_reg <= '0;
                end
            end
            if (cmd.step_byte) begin
                fill_reg <= fill_reg + 1'b1;
                if (size_reg != '1) begin
                    size_reg <= size_reg + 1'b1;
                end
            end
            if (cmd.close_file) begin
                file_open_reg <= 1'b0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        sts            = '0;
        sts.in_op      = s_item.opcode;
        sts.op         = item_reg.opcode;
        sts.need_pop   = need_pop;
        sts.list_empty = (free_head_reg == '0);
        sts.file_open  = file_open_reg;
        sts.out_free   = out_free;
        sts.sweep_last = sweep_last;
    end

endmodule

// File: design/fcba_ctrl.sv
module fcba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output fcba_pkg::dp_cmd_t   cmd,
    input  fcba_pkg::dp_sts_t   sts
);
    import fcba_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_FMT   = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_RDOUT = 4'd5;
    localparam logic [3:0] ST_POP   = 4'd6;
    localparam logic [3:0] ST_POPW  = 4'd7;
    localparam logic [3:0] ST_LINK  = 4'd8;
    localparam logic [3:0] ST_META  = 4'd9;
    localparam logic [3:0] ST_BODY  = 4'd10;
    localparam logic [3:0] ST_START = 4'd11;
    localparam logic [3:0] ST_FULL  = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (sts.in_op)
                        OP_FORMAT: begin
                            cmd.fmt_latch = 1'b1;
                            state_next    = ST_FMT;
                        end
                        OP_READ: begin
                            state_next = ST_RD;
                        end
                        default: begin
                            if (sts.need_pop && sts.list_empty) begin
                                state_next = ST_FULL;
                            end else if (sts.need_pop) begin
                                state_next = ST_POP;
                            end else if (sts.in_op == OP_BYTE && sts.out_free) begin
                                // plain byte inside the current block goes out at once
                                cmd.emit      = 1'b1;
                                cmd.res_sel   = RES_DATA;
                                cmd.direct    = 1'b1;
                                cmd.step_byte = 1'b1;
                            end else begin
                                state_next = ST_BODY;
                            end
                        end
                    endcase
                end
            end
            ST_FMT: begin
                cmd.sweep     = 1'b1;
                cmd.sweep_fmt = 1'b1;
                if (sts.sweep_last) begin
                    cmd.fmt_finish = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_ROOT;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_READ;
                    state_next  = ST_IDLE;
                end
            end
            ST_POP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_pop = 1'b1;
                state_next = ST_POPW;
            end
            ST_POPW: begin
                cmd.pop_commit = 1'b1;
                state_next     = sts.file_open ? ST_LINK : ST_META;
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_BODY;
            end
            ST_META: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_META;
                    state_next  = ST_BODY;
                end
            end
            ST_BODY: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.op == OP_BYTE) begin
                        cmd.res_sel   = RES_DATA;
                        cmd.step_byte = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.res_sel = RES_SIZE;
                        state_next  = ST_START;
                    end
                end
            end
            ST_START: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.res_sel    = RES_START;
                    cmd.close_file = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FULL: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_FULL;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/fat_chain_block_allocator.sv
// channel   ports                              moves
// s_        s_valid s_ready s_item             one opcode item (format, byte, end, read)
// m_        m_valid m_ready m_item             one result item, last set on final one
// cfg_      cfg_wr_en cfg_wr_data              total_blocks register, no wait
//
// a byte in the current block goes out from idle if the output is free; one needing
// a fresh block: table read, pop, link, emit; a file's first byte: table read, pop,
// meta, data; end of file: size, then start; format: whole-table sweep, then root;
// table read: read, then emit; after reset a clearing pass runs before s_ready rises
// results sit in a one-deep output register; a stalled m_ready holds the controller
module fat_chain_block_allocator #(
    parameter int MAX_BLOCKS  = fcba_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_BYTES = fcba_pkg::BLOCK_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [fcba_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fcba_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fcba_pkg::out_item_t         m_item
);
    import fcba_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    fcba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    fcba_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: verif/fat_chain_block_allocator_test.sv
module fat_chain_block_allocator_test;
    import fcba_pkg::*;

    localparam int NBLK          = MAX_BLOCKS_DEF;
    localparam int BLK_BYTES     = BLOCK_BYTES_DEF;
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 32;
    localparam logic [20:0] SIZE_CAP = 21'h1FFFFF;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_item_t         s_item      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_item_t        m_item;

    // shadow of the allocator
    bit [11:0]      fat [NBLK];
    bit [11:0]      free_blk;
    bit [11:0]      file_first;
    bit [11:0]      file_cur;
    bit             file_busy;
    bit [9:0]       fill_at;
    bit [20:0]      bytes_in_file;
    bit [CFG_W-1:0] image_blocks = TOTAL_BLOCKS_RST;

    in_item_t  pending_ops [$];
    out_item_t due_results [$];
    int        gap_left;
    int        stall_left;
    int        idle_cycles;
    int        fail_count;
    bit        no_gaps;

    fat_chain_block_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // switches now and then between gappy and back-to-back stretches
    function automatic int draw_wait();
        if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic int blocks_in_image();
        int n = image_blocks;
        if (n < MIN_BLOCKS)
            n = MIN_BLOCKS;
        if (n > NBLK)
            n = NBLK;
        return n;
    endfunction

    function automatic void post_result(logic [2:0] kind, logic [11:0] blk, logic [8:0] off,
                                        logic [20:0] val, logic fin);
        out_item_t r;
        r.kind         = kind;
        r.block_number = blk;
        r.byte_offset  = off;
        r.value        = val;
        r.last         = fin;
        due_results.push_back(r);
    endfunction

    function automatic logic [11:0] pop_free_block();
        logic [11:0] b;
        b = free_blk;
        free_blk = fat[b];
        fat[b] = '0;
        return b;
    endfunction

    function automatic void model_fat_op(in_item_t it);
        int          first_data;
        int          n;
        logic [11:0] b;
        case (it.opcode)
            OP_FORMAT: begin
                n = blocks_in_image();
                foreach (fat[i])
                    fat[i] = '0;
                first_data = 1 + (n * ENTRY_BYTES + BLK_BYTES - 1) / BLK_BYTES;
                for (int i = n - 1; i > first_data; i--)
                    fat[i] = 12'(i - 1);
                free_blk      = 12'(n - 1);
                file_busy     = 1'b0;
                file_first    = '0;
                file_cur      = '0;
                fill_at       = '0;
                bytes_in_file = '0;
                if (free_blk == 0)
                    post_result(K_FULL, '0, '0, '0, 1'b1);
                else
                    post_result(K_ROOT, pop_free_block(), '0, '0, 1'b1);
            end
            OP_READ: begin
                post_result(K_READ, it.entry_index, '0, 21'(fat[it.entry_index]), 1'b1);
            end
            default: begin
                if ((!file_busy || fill_at >= BLK_BYTES) && free_blk == 0) begin
                    post_result(K_FULL, '0, '0, '0, 1'b1);
                end else begin
                    if (!file_busy) begin
                        b             = pop_free_block();
                        file_first    = b;
                        file_cur      = b;
                        fill_at       = 10'(META_BYTES);
                        bytes_in_file = '0;
                        file_busy     = 1'b1;
                        post_result(K_META, b, '0, 21'd1, 1'b0);
                    end else if (fill_at >= BLK_BYTES) begin
                        // full block: chain a fresh one behind it
                        b             = pop_free_block();
                        fat[file_cur] = b;
                        file_cur      = b;
                        fill_at       = '0;
                    end
                    if (it.opcode == OP_BYTE) begin
                        post_result(K_DATA, file_cur, fill_at[8:0], 21'(it.data_byte), 1'b1);
                        fill_at++;
                        if (bytes_in_file != SIZE_CAP)
                            bytes_in_file++;
                    end else begin
                        post_result(K_META, file_first, 9'(SIZE_WORD_OFF), bytes_in_file, 1'b0);
                        post_result(K_START, file_first, '0, '0, 1'b1);
                        file_busy = 1'b0;
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [20:0] want, logic [20:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                model_fat_op(s_item);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_ops.size() != 0) begin
                    s_item   <= pending_ops.pop_front();
                    s_valid  <= 1'b1;
                    gap_left <= draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        out_item_t want;
        int        w;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %p",
                         $time, m_item);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", want.kind, m_item.kind);
                check_field("block_number", want.block_number, m_item.block_number);
                check_field("byte_offset", want.byte_offset, m_item.byte_offset);
                check_field("value", want.value, m_item.value);
                check_field("last", want.last, m_item.last);
            end
            w = draw_wait();
            stall_left <= w;
            m_ready    <= (w == 0);
        end else if (!m_ready) begin
            if (stall_left <= 1)
                m_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [7:0] dbyte, logic [11:0] idx);
        in_item_t it;
        it.opcode      = op;
        it.data_byte   = dbyte;
        it.entry_index = idx;
        pending_ops.push_back(it);
    endtask

    task automatic send_op(logic [1:0] op);
        send(op, 8'($urandom), 12'($urandom));
    endtask

    task automatic send_file(int len);
        for (int i = 0; i < len; i++)
            send_op(OP_BYTE);
        send_op(OP_END);
    endtask

    // sample between edges so the driver and checker updates have landed
    task automatic settle();
        do
            @(negedge aclk);
        while (pending_ops.size() != 0 || s_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_blocks(logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        image_blocks = v;
    endtask

    task automatic random_traffic(logic [CFG_W-1:0] blocks, int count);
        int  sent;
        int  len;
        int  r;
        int  top;
        set_blocks(blocks);
        top = blocks_in_image();
        send_op(OP_FORMAT);
        sent = 1;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                len = $urandom_range(0, 20);
                send_file(len);
                sent += len + 1;
            end else if (r < 80) begin
                if ($urandom_range(0, 1))
                    send(OP_READ, 8'($urandom), 12'($urandom_range(0, 4095)));
                else
                    send(OP_READ, 8'($urandom),
                         12'($urandom_range(top > 12 ? top - 12 : 0, top - 1)));
                sent++;
            end else if (r < 90) begin
                // bytes with no end item, the next file picks them up
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_op(OP_BYTE);
                sent += len;
            end else if (r < 96) begin
                send_op(OP_END);
                sent++;
            end else begin
                send_op(OP_FORMAT);
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // above the table size, taken as the full table
        set_blocks(13'd8191);
        // nothing formatted yet: empty free list
        send(OP_READ, 8'h00, 12'd0);
        send(OP_BYTE, 8'h00, 12'd0);
        send(OP_END, 8'h00, 12'd0);
        send(OP_FORMAT, 8'h00, 12'd0);
        send(OP_READ, 8'h00, 12'd4095);
        send(OP_READ, 8'h00, 12'd4094);
        send(OP_READ, 8'h00, 12'd34);
        send(OP_READ, 8'h00, 12'd33);
        send(OP_BYTE, 8'h00, 12'hFFF);
        send(OP_BYTE, 8'hFF, 12'h000);
        send(OP_BYTE, 8'h5A, 12'h000);
        send(OP_END, 8'hFF, 12'hFFF);
        send(OP_END, 8'h00, 12'd0);
        send(OP_READ, 8'h00, 12'd4094);
        // format while a file is open drops the file
        send(OP_BYTE, 8'hA5, 12'd0);
        send(OP_FORMAT, 8'h00, 12'd0);
        send(OP_END, 8'h00, 12'd0);
        settle();

        // below the minimum: four blocks, a single one left for files
        set_blocks(13'd0);
        send_op(OP_FORMAT);
        send_file(3);
        send_op(OP_END);
        send_op(OP_BYTE);
        send(OP_READ, 8'h00, 12'd2);
        send(OP_READ, 8'h00, 12'd3);
        send_op(OP_FORMAT);
        send_op(OP_END);
        send(OP_READ, 8'h00, 12'd2);
        settle();

        // five blocks: two files use up the free list
        set_blocks(13'd5);
        send_op(OP_FORMAT);
        send_file(4);
        send_file(2);
        send_file(1);
        send(OP_READ, 8'h00, 12'd3);
        send(OP_READ, 8'h00, 12'd2);
        settle();

        random_traffic(13'd4096, 25);
        random_traffic(13'd6, 25);
        random_traffic(13'($urandom_range(4, 8191)), 25);
        random_traffic(13'($urandom_range(0, 3)), 20);
        random_traffic(13'($urandom_range(7, 300)), 25);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
